// ===== hw/rtl/dkst_pkg.sv =====
// dkst_pkg: types, codes and constants for the dual-key session table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dkst_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int RESULT_LIMIT = 64;
    localparam int RES_W = $clog2(RESULT_LIMIT + 1);

    localparam logic [2:0] CMD_UPD_IP  = 3'd0;
    localparam logic [2:0] CMD_UPD_SID = 3'd1;
    localparam logic [2:0] CMD_LKP_IP  = 3'd2;
    localparam logic [2:0] CMD_LKP_SID = 3'd3;
    localparam logic [2:0] CMD_DELETE  = 3'd4;
    localparam logic [2:0] CMD_SWEEP   = 3'd5;
    localparam logic [2:0] CMD_REPORT  = 3'd6;
    localparam logic [2:0] CMD_UNUSED  = 3'd7;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_MISS      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_RECLAIMED = 3'd4;
    localparam logic [2:0] ST_IDLE      = 3'd5;
    localparam logic [2:0] ST_NONE      = 3'd6;

    localparam logic [1:0] REG_RECLAIM = 2'd0;
    localparam logic [1:0] REG_PROBE   = 2'd1;
    localparam logic [1:0] REG_DEAD    = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] vaddr;
        logic [31:0] sess_key;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_ip;
        logic [31:0] found_sid;
        logic [31:0] found_peer_ip;
        logic [15:0] found_peer_port;
        logic        is_dead;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [31:0] sid;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [31:0] seen_at;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXAM,
        S_FINISH,
        S_EMIT
    } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dual_key_session_table.sv =====
// dual_key_session_table: session table keyed by virtual ip or session id, uses dkst_pkg
// each command scans the slot memory from slot 0, with a read and an exam step per slot
// a keyed miss and a sweep/report scan every slot; a keyed hit ends the scan at that slot
// a new command is taken only in idle, once the previous one has handed off its results
// reset: table empty (valid bits cleared), registers at defaults, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module dual_key_session_table (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire dkst_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire                      out_ready,
    output dkst_pkg::out_item_t      out_data,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire  [3:0]               paddr,
    input  wire  [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import dkst_pkg::*;

    slot_t mem [TABLE_ENTRIES];
    slot_t rd_reg;
    logic  [TABLE_ENTRIES-1:0] valid_reg;

    logic [15:0] reclaim_reg, probe_reg, dead_reg;
    logic [6:0]  limit_reg;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [RES_W-1:0] n_reg, n_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t pend_reg, pend_next;
    logic      pend_valid_reg, pend_valid_next;

    out_item_t        res;
    logic             scan_done;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic             set_v, clr_v;
    logic [IDX_W-1:0] v_addr;

    logic [IDX_W-1:0] cur;
    logic [31:0] idle;
    logic        cur_valid, match_ip, match_sid;
    logic [RES_W-1:0] lim;
    logic        scan_cmd;
    logic        out_free;

    assign pready    = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cur       = idx_reg;
    assign idle      = item_reg.now - rd_reg.seen_at;
    assign cur_valid = valid_reg[cur];
    assign match_ip  = cur_valid && (rd_reg.ip == item_reg.vaddr);
    assign match_sid = cur_valid && (rd_reg.sid == item_reg.sess_key);
    assign scan_cmd  = (item_reg.cmd == CMD_SWEEP) || (item_reg.cmd == CMD_REPORT);
    // exam only proceeds when the output register is free
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (limit_reg == 7'd0)
            lim = RES_W'(1);
        else if ({25'd0, limit_reg} > RESULT_LIMIT)
            lim = RES_W'(RESULT_LIMIT);
        else
            lim = RES_W'(limit_reg);
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_RECLAIM: prdata = {16'd0, reclaim_reg};
            REG_PROBE:   prdata = {16'd0, probe_reg};
            REG_DEAD:    prdata = {16'd0, dead_reg};
            REG_LIMIT:   prdata = {25'd0, limit_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reclaim_reg <= 16'd120;
            probe_reg   <= 16'd30;
            dead_reg    <= 16'd90;
            limit_reg   <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_RECLAIM: reclaim_reg <= pwdata[15:0];
                REG_PROBE:   probe_reg   <= pwdata[15:0];
                REG_DEAD:    dead_reg    <= pwdata[15:0];
                REG_LIMIT:   limit_reg   <= pwdata[6:0];
                default:     ;
            endcase
        end
    end

    // slot memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[cur];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (set_v)
            valid_reg[v_addr] <= 1'b1;
        else if (clr_v)
            valid_reg[v_addr] <= 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_READ;
            S_READ:   if (out_free) state_next = S_EXAM;
            S_EXAM:   state_next = scan_done ? S_FINISH : S_READ;
            S_FINISH: if (out_free) state_next = S_EMIT;
            S_EMIT:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next        = idx_reg;
        n_next          = n_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        scan_done       = 1'b0;
        res                 = '0;
        res.found_ip        = rd_reg.ip;
        res.found_sid       = rd_reg.sid;
        res.found_peer_ip   = rd_reg.peer_ip;
        res.found_peer_port = rd_reg.peer_port;
        wr_en   = 1'b0;
        wr_addr = cur;
        wr_data = rd_reg;
        set_v   = 1'b0;
        clr_v   = 1'b0;
        v_addr  = cur;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                n_next = '0;
                free_found_next = 1'b0;
            end
            S_EXAM:
            begin
                idx_next = idx_reg + IDX_W'(1);
                case (item_reg.cmd)
                    CMD_UPD_IP:
                    begin
                        if (!cur_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next = cur;
                        end
                        if (match_ip)
                        begin
                            wr_en = 1'b1;
                            wr_data.sid = item_reg.sess_key;
                            wr_data.peer_ip = item_reg.peer_ip;
                            wr_data.peer_port = item_reg.peer_port;
                            wr_data.seen_at = item_reg.now;
                            res.status = ST_HIT;
                            res.found_sid = item_reg.sess_key;
                            res.found_peer_ip = item_reg.peer_ip;
                            res.found_peer_port = item_reg.peer_port;
                            res.last = 1'b1;
                            scan_done = 1'b1;
                        end
                        else if (idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                        begin
                            scan_done = 1'b1;
                            res = '0;
                            res.last = 1'b1;
                            res.found_ip = item_reg.vaddr;
                            res.found_sid = item_reg.sess_key;
                            if (free_found_next)
                            begin
                                wr_en = 1'b1;
                                wr_addr = free_idx_next;
                                wr_data.ip = item_reg.vaddr;
                                wr_data.sid = item_reg.sess_key;
                                wr_data.peer_ip = item_reg.peer_ip;
                                wr_data.peer_port = item_reg.peer_port;
                                wr_data.seen_at = item_reg.now;
                                set_v = 1'b1;
                                v_addr = free_idx_next;
                                res.status = ST_CREATED;
                                res.found_peer_ip = item_reg.peer_ip;
                                res.found_peer_port = item_reg.peer_port;
                            end
                            else
                                res.status = ST_FULL;
                        end
                    end
                    CMD_UPD_SID, CMD_LKP_SID:
                    begin
                        if (match_sid)
                        begin
                            res.status = ST_HIT;
                            if (item_reg.cmd == CMD_UPD_SID)
                            begin
                                wr_en = 1'b1;
                                wr_data.peer_ip = item_reg.peer_ip;
                                wr_data.peer_port = item_reg.peer_port;
                                wr_data.seen_at = item_reg.now;
                                res.found_peer_ip = item_reg.peer_ip;
                                res.found_peer_port = item_reg.peer_port;
                            end
                            res.last = 1'b1;
                            scan_done = 1'b1;
                        end
                        else if (idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                        begin
                            res = '0;
                            res.status = ST_MISS;
                            res.found_sid = item_reg.sess_key;
                            res.last = 1'b1;
                            scan_done = 1'b1;
                        end
                    end
                    CMD_LKP_IP, CMD_DELETE:
                    begin
                        if (match_ip)
                        begin
                            res.status = ST_HIT;
                            res.last = 1'b1;
                            scan_done = 1'b1;
                            clr_v = (item_reg.cmd == CMD_DELETE);
                        end
                        else if (idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                        begin
                            res = '0;
                            res.status = ST_MISS;
                            res.found_ip = item_reg.vaddr;
                            res.last = 1'b1;
                            scan_done = 1'b1;
                        end
                    end
                    CMD_SWEEP, CMD_REPORT:
                    begin
                        if (item_reg.cmd == CMD_SWEEP &&
                            cur_valid && idle > {16'd0, reclaim_reg} &&
                            n_reg < RES_W'(RESULT_LIMIT))
                        begin
                            res.status = ST_RECLAIMED;
                            n_next = n_reg + RES_W'(1);
                            clr_v = 1'b1;
                        end
                        else if (item_reg.cmd == CMD_REPORT &&
                            cur_valid && idle >= {16'd0, probe_reg} && n_reg < lim)
                        begin
                            res.status = ST_IDLE;
                            res.is_dead = (idle >= {16'd0, dead_reg});
                            n_next = n_reg + RES_W'(1);
                        end
                        if (idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                            scan_done = 1'b1;
                    end
                    default:
                    begin
                        scan_done = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // scan results wait in pend_reg for the next one or the finish, so the final one can carry last
    always_comb
    begin
        pend_next = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
                pend_valid_next = 1'b0;
            S_EXAM:
            begin
                if (scan_cmd)
                begin
                    if (n_next != n_reg)
                    begin
                        pend_next = res;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_next = pend_reg;
                            out_valid_next = 1'b1;
                        end
                    end
                end
                else if (scan_done && item_reg.cmd != CMD_UNUSED)
                begin
                    out_next = res;
                    out_valid_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free && (scan_cmd || item_reg.cmd == CMD_UNUSED))
                begin
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next = '0;
                        out_next.status = ST_NONE;
                        out_next.last = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_data;
        free_idx_reg <= free_idx_next;
        pend_reg <= pend_next;
        out_reg <= out_next;
    end
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for dual_key_session_table, with a scoreboard class
// that predicts every result from the command stream; depends on dkst_pkg and the rtl
`timescale 1ns / 1ps
module tb_top;
    import dkst_pkg::*;

    class session_scoreboard;
        bit          used[TABLE_ENTRIES];
        slot_t       ent[TABLE_ENTRIES];
        logic [15:0] reclaim_to, probe_to, dead_to;
        logic [6:0]  rpt_limit;
        out_item_t   expected_q[$];
        int          errors;

        function new();
            errors = 0;
            reclaim_to = 16'd120;
            probe_to = 16'd30;
            dead_to = 16'd90;
            rpt_limit = 7'd64;
            foreach (used[i])
            begin
                used[i] = 1'b0;
                ent[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_RECLAIM: reclaim_to = v[15:0];
                REG_PROBE:   probe_to = v[15:0];
                REG_DEAD:    dead_to = v[15:0];
                REG_LIMIT:   rpt_limit = v[6:0];
                default:     ;
            endcase
        endfunction

        function int find_ip(logic [31:0] ip);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (used[i] && ent[i].ip == ip) return i;
            return -1;
        endfunction

        function int find_sid(logic [31:0] sid);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (used[i] && ent[i].sid == sid) return i;
            return -1;
        endfunction

        function out_item_t raw(logic [2:0] st, logic [31:0] ip, logic [31:0] sid,
                                logic [31:0] pip, logic [15:0] pport, logic dead);
            out_item_t r;
            r.status = st;
            r.found_ip = ip;
            r.found_sid = sid;
            r.found_peer_ip = pip;
            r.found_peer_port = pport;
            r.is_dead = dead;
            r.last = 1'b0;
            return r;
        endfunction

        function out_item_t from_slot(logic [2:0] st, int s, logic dead);
            return raw(st, ent[s].ip, ent[s].sid, ent[s].peer_ip, ent[s].peer_port, dead);
        endfunction

        // note an accepted command and queue the results it must cause
        function void note_command(in_item_t it);
            out_item_t res[$];
            out_item_t r;
            int s;
            int lim;
            logic [31:0] idle;
            case (it.cmd)
                CMD_UPD_IP:
                begin
                    s = find_ip(it.vaddr);
                    if (s >= 0)
                    begin
                        ent[s].sid = it.sess_key;
                        ent[s].peer_ip = it.peer_ip;
                        ent[s].peer_port = it.peer_port;
                        ent[s].seen_at = it.now;
                        res.push_back(from_slot(ST_HIT, s, 1'b0));
                    end
                    else
                    begin
                        s = -1;
                        for (int i = 0; i < TABLE_ENTRIES && s < 0; i++)
                            if (!used[i]) s = i;
                        if (s >= 0)
                        begin
                            used[s] = 1'b1;
                            ent[s].ip = it.vaddr;
                            ent[s].sid = it.sess_key;
                            ent[s].peer_ip = it.peer_ip;
                            ent[s].peer_port = it.peer_port;
                            ent[s].seen_at = it.now;
                            res.push_back(from_slot(ST_CREATED, s, 1'b0));
                        end
                        else
                            res.push_back(raw(ST_FULL, it.vaddr, it.sess_key,
                                              '0, '0, 1'b0));
                    end
                end
                CMD_UPD_SID:
                begin
                    s = find_sid(it.sess_key);
                    if (s >= 0)
                    begin
                        ent[s].peer_ip = it.peer_ip;
                        ent[s].peer_port = it.peer_port;
                        ent[s].seen_at = it.now;
                        res.push_back(from_slot(ST_HIT, s, 1'b0));
                    end
                    else
                        res.push_back(raw(ST_MISS, '0, it.sess_key, '0, '0, 1'b0));
                end
                CMD_LKP_IP, CMD_DELETE:
                begin
                    s = find_ip(it.vaddr);
                    if (s >= 0)
                    begin
                        res.push_back(from_slot(ST_HIT, s, 1'b0));
                        if (it.cmd == CMD_DELETE) used[s] = 1'b0;
                    end
                    else
                        res.push_back(raw(ST_MISS, it.vaddr, '0, '0, '0, 1'b0));
                end
                CMD_LKP_SID:
                begin
                    s = find_sid(it.sess_key);
                    if (s >= 0)
                        res.push_back(from_slot(ST_HIT, s, 1'b0));
                    else
                        res.push_back(raw(ST_MISS, '0, it.sess_key, '0, '0, 1'b0));
                end
                CMD_SWEEP:
                begin
                    for (int i = 0; i < TABLE_ENTRIES && res.size() < RESULT_LIMIT; i++)
                    begin
                        idle = it.now - ent[i].seen_at;
                        if (used[i] && idle > {16'd0, reclaim_to})
                        begin
                            res.push_back(from_slot(ST_RECLAIMED, i, 1'b0));
                            used[i] = 1'b0;
                        end
                    end
                end
                CMD_REPORT:
                begin
                    lim = rpt_limit;
                    if (lim == 0) lim = 1;
                    if (lim > RESULT_LIMIT) lim = RESULT_LIMIT;
                    for (int i = 0; i < TABLE_ENTRIES && res.size() < lim; i++)
                    begin
                        idle = it.now - ent[i].seen_at;
                        if (used[i] && idle >= {16'd0, probe_to})
                            res.push_back(from_slot(ST_IDLE, i, idle >= {16'd0, dead_to}));
                    end
                end
                default: ;
            endcase
            if (res.size() == 0) res.push_back(raw(ST_NONE, '0, '0, '0, '0, 1'b0));
            foreach (res[i])
            begin
                r = res[i];
                r.last = (i == res.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        function void field_diff(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result: actual %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            field_diff("status", e.status, got.status);
            field_diff("found_ip", e.found_ip, got.found_ip);
            field_diff("found_sid", e.found_sid, got.found_sid);
            field_diff("found_peer_ip", e.found_peer_ip, got.found_peer_ip);
            field_diff("found_peer_port", e.found_peer_port, got.found_peer_port);
            field_diff("is_dead", e.is_dead, got.is_dead);
            field_diff("last", e.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    session_scoreboard sb;
    bit          stall_on;
    logic [31:0] tnow;
    logic [31:0] ip_pool[8];
    logic [31:0] sid_pool[8];

    dual_key_session_table uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stall before each transfer while stall_on is set
    initial
    begin
        int k;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            k = stall_on ? $urandom_range(0, 10) : 0;
            if (k > 0)
            begin
                out_ready <= 1'b0;
                repeat (k) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);

    task automatic send_cmd(in_item_t it);
        int gap;
        gap = stall_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_command(it);
        @(negedge clk);
    endtask

    // let every queued result drain, then give the block time to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] rc, logic [31:0] pr, logic [31:0] dd,
                            logic [31:0] lm);
        write_reg(REG_RECLAIM, rc);
        write_reg(REG_PROBE, pr);
        write_reg(REG_DEAD, dd);
        write_reg(REG_LIMIT, lm);
    endtask

    function automatic in_item_t mk(logic [2:0] c, logic [31:0] ip, logic [31:0] sid,
                                    logic [31:0] pip, logic [15:0] pp, logic [31:0] t);
        in_item_t it;
        it.cmd = c;
        it.vaddr = ip;
        it.sess_key = sid;
        it.peer_ip = pip;
        it.peer_port = pp;
        it.now = t;
        return it;
    endfunction

    function automatic in_item_t rand_cmd();
        logic [2:0] c;
        logic [31:0] ip, sid, t;
        int w;
        w = $urandom_range(0, 99);
        if (w < 30) c = CMD_UPD_IP;
        else if (w < 42) c = CMD_UPD_SID;
        else if (w < 56) c = CMD_LKP_IP;
        else if (w < 68) c = CMD_LKP_SID;
        else if (w < 80) c = CMD_DELETE;
        else if (w < 88) c = CMD_SWEEP;
        else if (w < 97) c = CMD_REPORT;
        else c = CMD_UNUSED;
        ip = ($urandom_range(0, 9) < 8) ? ip_pool[$urandom_range(0, 7)] : $urandom;
        sid = ($urandom_range(0, 9) < 8) ? sid_pool[$urandom_range(0, 7)] : $urandom;
        tnow = tnow + $urandom_range(0, 40);
        w = $urandom_range(0, 19);
        if (w == 0) tnow = $urandom;
        t = (w == 1) ? tnow - $urandom_range(1, 100) : tnow;
        return mk(c, ip, sid, $urandom, 16'($urandom_range(0, 16'hffff)), t);
    endfunction

    initial
    begin
        logic [31:0] a, b;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_on = 1'b1;
        tnow = 32'd1000;
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hffffffff;
        sid_pool[0] = 32'h0;
        sid_pool[1] = 32'hffffffff;
        for (int i = 2; i < 8; i++)
        begin
            ip_pool[i] = $urandom;
            sid_pool[i] = $urandom;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: defaults still in force
        a = 32'h12345678;
        b = 32'h9abcdef0;
        send_cmd(mk(CMD_SWEEP, 0, 0, 0, 0, 32'd5000));
        send_cmd(mk(CMD_REPORT, 0, 0, 0, 0, 32'd5000));
        send_cmd(mk(CMD_UPD_IP, 32'h0, 32'h0, 32'h0, 16'h0, 32'd0));
        send_cmd(mk(CMD_UPD_IP, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    16'hffff, 32'hffffffff));
        send_cmd(mk(CMD_UPD_IP, a, b, 32'h0a000001, 16'd4500, 32'd100));
        send_cmd(mk(CMD_UPD_IP, a, 32'h0, 32'h0a000002, 16'd4501, 32'd110));
        send_cmd(mk(CMD_UPD_SID, 0, 32'h0, 32'hc0a80001, 16'd500, 32'd120));
        send_cmd(mk(CMD_UPD_SID, 0, b, 32'hc0a80001, 16'd500, 32'd120));
        send_cmd(mk(CMD_LKP_IP, a, 0, 0, 0, 0));
        send_cmd(mk(CMD_LKP_IP, b, 0, 0, 0, 0));
        send_cmd(mk(CMD_LKP_SID, 0, 32'h0, 0, 0, 0));
        send_cmd(mk(CMD_LKP_SID, 0, 32'h5555aaaa, 0, 0, 0));
        send_cmd(mk(CMD_REPORT, 0, 0, 0, 0, 32'd140));
        send_cmd(mk(CMD_REPORT, 0, 0, 0, 0, 32'd200));
        send_cmd(mk(CMD_DELETE, a, 0, 0, 0, 0));
        send_cmd(mk(CMD_DELETE, a, 0, 0, 0, 0));
        send_cmd(mk(CMD_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff,
                    32'hffffffff));
        send_cmd(mk(CMD_SWEEP, 0, 0, 0, 0, 32'd120));
        send_cmd(mk(CMD_SWEEP, 0, 0, 0, 0, 32'd121));
        send_cmd(mk(CMD_SWEEP, 0, 0, 0, 0, 32'h7fffffff));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(0, 0, 0, 0);
                1: set_regs(32'hffff, 32'hffff, 32'hffff, 32'h7f);
                2: set_regs(120, 30, 90, 64);
                3: set_regs(20, 5, 40, 1);
                4: set_regs($urandom_range(0, 200), $urandom_range(0, 100),
                            $urandom_range(0, 200), $urandom_range(1, 64));
                default: set_regs(60, 10, 30, 3);
            endcase
            stall_on = (ph != 3);
            // fill the table past capacity, then clear it out
            if (ph == 2)
            begin
                for (int i = 0; i < 68; i++)
                    send_cmd(mk(CMD_UPD_IP, $urandom, $urandom, $urandom,
                                16'($urandom_range(0, 16'hffff)), tnow + i));
                send_cmd(mk(CMD_REPORT, 0, 0, 0, 0, tnow + 200));
                send_cmd(mk(CMD_SWEEP, 0, 0, 0, 0, tnow + 500));
                tnow = tnow + 500;
            end
            for (int i = 0; i < 50; i++)
                send_cmd(rand_cmd());
            drain();
        end

        drain();
        repeat (150) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/dkst_pkg.sv
hw/rtl/dual_key_session_table.sv
sim/tb_top.sv
